[hdl/twuf_pkg.sv]
// shared types and constants for the table-weighted 2d upsample filter
// no dependencies; imported by every module of the block
package twuf_pkg;

  // window geometry
  localparam int LUMA_TAPS   = 6;
  localparam int CHROMA_TAPS = 4;

  // field and datapath widths
  localparam int PIX_W      = 10;
  localparam int WGT_W      = 16;
  localparam int SET_W      = 6;
  localparam int ROW_W      = 3;
  localparam int ACC_W      = 32;
  localparam int OUT_W      = 16;
  localparam int SHIFT_W    = 5;
  localparam int PROD_W     = PIX_W + 1 + WGT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int LVL_W       = $clog2(QUEUE_DEPTH + 1);

  // clip limits and register reset values
  localparam logic [OUT_W-1:0]   CLIP_MAX_8    = 16'h00ff;
  localparam logic [OUT_W-1:0]   CLIP_MAX_16   = 16'hffff;
  localparam logic [SHIFT_W-1:0] DESCALE_RESET = 5'd14;

  // request function codes
  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_FILTER = 1'b1
  } func_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHROMA_MODE    = 2'd0,
    REG_HIGH_BIT_DEPTH = 2'd1,
    REG_DESCALE        = 2'd2
  } cfg_reg_t;

  typedef logic [LUMA_TAPS-1:0][PIX_W-1:0] pix_row_t;
  typedef logic [LUMA_TAPS-1:0][WGT_W-1:0] wgt_row_t;

  // live configuration
  typedef struct packed {
    logic               chroma_mode;
    logic               high_bit_depth;
    logic [SHIFT_W-1:0] descale;
  } cfg_t;

  // one classified filter row, handed from front to back
  typedef struct packed {
    pix_row_t pix;
    wgt_row_t wgt;
    logic     chroma;
    logic     row_ok;
    logic     last;
  } filt_entry_t;

endpackage

[hdl/twuf_front.sv]
// front end: request intake, weight store (one bank per tap column), classification
// depends on twuf_pkg; feeds twuf_queue
module twuf_front
  import twuf_pkg::*;
#(
  parameter int NUM_WEIGHT_SETS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              func,
  input  logic [SET_W-1:0]  set_index,
  input  logic [ROW_W-1:0]  row_index,
  input  logic [ROW_W-1:0]  tap_index,
  input  logic [WGT_W-1:0]  weight_value,
  input  pix_row_t          pix,
  input  logic              last_row,
  input  logic              chroma_mode,
  input  logic [LVL_W-1:0]  q_level,
  output logic              push,
  output filt_entry_t       push_entry
);

  localparam int BANK_DEPTH = NUM_WEIGHT_SETS * LUMA_TAPS;
  localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam logic [31:0]      NUM_SETS   = 32'(NUM_WEIGHT_SETS);
  localparam logic [ROW_W-1:0] LUMA_ROWS  = ROW_W'(LUMA_TAPS);
  localparam logic [ROW_W-1:0] CHROMA_ROWS = ROW_W'(CHROMA_TAPS);

  logic              accept;
  logic              is_load;
  logic              set_ok;
  logic              wr_en;
  logic [ROW_W-1:0]  row_lim;
  logic [31:0]       addr_wide;
  logic [ADDR_W-1:0] addr;
  wgt_row_t          rd_wgt;

  // stage holding the request while the store read completes
  logic              s1_valid;
  pix_row_t          s1_pix;
  logic              s1_chroma;
  logic              s1_row_ok;
  logic              s1_last;

  // credit check: queue entries plus the one in flight
  assign in_stall = (32'(q_level) + 32'(s1_valid)) >= 32'(QUEUE_DEPTH);
  assign accept   = in_valid && !in_stall;

  // classify the request
  assign is_load   = (func_t'(func) == FUNC_LOAD);
  assign set_ok    = (32'(set_index) < NUM_SETS);
  assign row_lim   = chroma_mode ? CHROMA_ROWS : LUMA_ROWS;
  assign wr_en     = accept && is_load && set_ok &&
                     (row_index < LUMA_ROWS) && (tap_index < LUMA_ROWS);
  assign addr_wide = 32'(set_index) * 32'(LUMA_TAPS) + 32'(row_index);
  assign addr      = addr_wide[ADDR_W-1:0];

  // one weight bank per column, all read at the same row address
  for (genvar c = 0; c < LUMA_TAPS; c++) begin : g_bank
    logic [WGT_W-1:0] mem [BANK_DEPTH];
    logic [WGT_W-1:0] rd_q;

    always_ff @(posedge clk) begin
      if (wr_en && (tap_index == ROW_W'(c))) begin
        mem[addr] <= weight_value;
      end
      rd_q <= mem[addr];
    end

    assign rd_wgt[c] = rd_q;
  end

  // filter request waits here for its registered weights
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && !is_load;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix    <= pix;
      s1_chroma <= chroma_mode;
      s1_row_ok <= set_ok && (row_index < row_lim);
      s1_last   <= last_row;
    end
  end

  // hand the classified row to the queue
  assign push = s1_valid;

  always_comb begin
    push_entry.pix    = s1_pix;
    push_entry.wgt    = rd_wgt;
    push_entry.chroma = s1_chroma;
    push_entry.row_ok = s1_row_ok;
    push_entry.last   = s1_last;
  end

endmodule

[hdl/twuf_queue.sv]
// short fifo of classified filter rows between front and back
// depends on twuf_pkg
module twuf_queue
  import twuf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  filt_entry_t      push_data,
  input  logic             pop,
  output filt_entry_t      pop_data,
  output logic             not_empty,
  output logic [LVL_W-1:0] level
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  filt_entry_t      slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] count;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + LVL_W'(1);
        2'b01:   count <= count - LVL_W'(1);
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign pop_data  = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign level     = count;

endmodule

[hdl/twuf_back.sv]
// back end: multiply, accumulate, round, shift, clip and output register
// depends on twuf_pkg; drains twuf_queue
module twuf_back
  import twuf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  filt_entry_t        q_data,
  output logic               pop,
  input  logic               high_bit_depth,
  input  logic [SHIFT_W-1:0] descale,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [OUT_W-1:0]   pixel_out
);

  logic adv;

  logic signed [PROD_W-1:0] prod [LUMA_TAPS];
  logic [ACC_W-1:0]         psum;
  logic [ACC_W-1:0]         rnd;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-1:0]         lim;
  logic [OUT_W-1:0]         clipped;

  // pipeline registers
  logic                     b1_valid;
  logic                     b1_last;
  logic signed [PROD_W-1:0] b1_prod [LUMA_TAPS];
  logic [ACC_W-1:0]         acc;
  logic                     b2_valid;
  logic [ACC_W-1:0]         b2_sum;
  logic                     b3_valid;
  logic [ACC_W-1:0]         b3_rnd;

  // whole back end moves unless a finished pixel is held
  assign adv = !out_valid || !out_stall;
  assign pop = adv && q_not_empty;

  // per-column products, zero for unused columns or rows
  always_comb begin
    for (int c = 0; c < LUMA_TAPS; c++) begin
      if (q_data.row_ok && (!q_data.chroma || (c < CHROMA_TAPS))) begin
        prod[c] = $signed({1'b0, q_data.pix[c]}) * $signed(q_data.wgt[c]);
      end else begin
        prod[c] = '0;
      end
    end
  end

  // row sum onto the wrapping accumulator
  always_comb begin
    psum = acc;
    for (int c = 0; c < LUMA_TAPS; c++) begin
      psum = psum + ACC_W'(b1_prod[c]);
    end
  end

  // rounding constant: half of the shift step
  always_comb begin
    if (descale == '0) begin
      rnd = '0;
    end else begin
      rnd = ACC_W'(1) << (descale - SHIFT_W'(1));
    end
  end

  // arithmetic shift and clip
  always_comb begin
    shifted = $signed(b3_rnd) >>> descale;
    lim     = high_bit_depth ? ACC_W'(CLIP_MAX_16) : ACC_W'(CLIP_MAX_8);
    if (shifted[ACC_W-1]) begin
      clipped = '0;
    end else if (ACC_W'(shifted) > lim) begin
      clipped = lim[OUT_W-1:0];
    end else begin
      clipped = shifted[OUT_W-1:0];
    end
  end

  // control: valid bits and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      b3_valid  <= 1'b0;
      out_valid <= 1'b0;
      acc       <= '0;
    end else if (adv) begin
      b1_valid  <= pop;
      b2_valid  <= b1_valid && b1_last;
      b3_valid  <= b2_valid;
      out_valid <= b3_valid;
      if (b1_valid) begin
        acc <= b1_last ? '0 : psum;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      if (pop) begin
        b1_prod <= prod;
        b1_last <= q_data.last;
      end
      b2_sum <= psum;
      b3_rnd <= b2_sum + rnd;
      if (b3_valid) begin
        pixel_out <= clipped;
      end
    end
  end

endmodule

[hdl/table_weighted_2d_upsample_filter.sv]
// top level of the table-weighted 2d upsample filter
// depends on twuf_pkg, twuf_front, twuf_queue, twuf_back
//
// Builds one output pixel from a 6x6 (luma) or 4x4 (chroma) source window, one window
// row per request. Load requests (func 0) write one signed weight word into the store;
// filter requests (func 1) multiply a row by its weight row and accumulate; the request
// flagged last_row rounds, shifts, clips and delivers pixel_out. The block takes one
// request per clock while in_stall is low: the weight store is split into six column
// banks read in parallel, so a whole row is fetched in a single access. A filtered
// pixel passes the front register for the store read, a queue slot, the product
// register, then accumulate, round, and shift/clip before it is offered. A four-entry
// queue parts front and back, so a held output stalls the back end alone until the
// queue fills. The weight store holds no reset value: load every weight a filter will
// use first. Write configuration only while the block is idle.
module table_weighted_2d_upsample_filter
  import twuf_pkg::*;
#(
  parameter int NUM_WEIGHT_SETS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  func,
  input  logic [SET_W-1:0]      set_index,
  input  logic [ROW_W-1:0]      row_index,
  input  logic [ROW_W-1:0]      tap_index,
  input  logic signed [WGT_W-1:0] weight_value,
  input  logic [PIX_W-1:0]      pix_a,
  input  logic [PIX_W-1:0]      pix_b,
  input  logic [PIX_W-1:0]      pix_c,
  input  logic [PIX_W-1:0]      pix_d,
  input  logic [PIX_W-1:0]      pix_e,
  input  logic [PIX_W-1:0]      pix_f,
  input  logic                  last_row,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_W-1:0]      pixel_out,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg;
  pix_row_t         pix_row;
  logic             push;
  filt_entry_t      push_entry;
  logic             pop;
  filt_entry_t      pop_entry;
  logic             q_not_empty;
  logic [LVL_W-1:0] q_level;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chroma_mode    <= 1'b0;
      cfg.high_bit_depth <= 1'b0;
      cfg.descale        <= DESCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CHROMA_MODE:    cfg.chroma_mode    <= cfg_data[0];
        REG_HIGH_BIT_DEPTH: cfg.high_bit_depth <= cfg_data[0];
        REG_DESCALE:        cfg.descale        <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // window row, column 0 first
  assign pix_row = {pix_f, pix_e, pix_d, pix_c, pix_b, pix_a};

  twuf_front #(
    .NUM_WEIGHT_SETS (NUM_WEIGHT_SETS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .set_index    (set_index),
    .row_index    (row_index),
    .tap_index    (tap_index),
    .weight_value (weight_value),
    .pix          (pix_row),
    .last_row     (last_row),
    .chroma_mode  (cfg.chroma_mode),
    .q_level      (q_level),
    .push         (push),
    .push_entry   (push_entry)
  );

  twuf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .pop_data  (pop_entry),
    .not_empty (q_not_empty),
    .level     (q_level)
  );

  twuf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_not_empty    (q_not_empty),
    .q_data         (pop_entry),
    .pop            (pop),
    .high_bit_depth (cfg.high_bit_depth),
    .descale        (cfg.descale),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pixel_out      (pixel_out)
  );

endmodule

[verif/table_weighted_2d_upsample_filter_tb.sv]
// self-checking testbench for the table-weighted 2d upsample filter
// depends on twuf_pkg and table_weighted_2d_upsample_filter; directed tests, then random
// windows and loads under random idling, checked against an in-bench pixel predictor
module table_weighted_2d_upsample_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import twuf_pkg::*;

  localparam int NUM_SETS     = 64;
  localparam int MAX_IDLE     = 12;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 850;
  localparam int PHASE_ITEMS  = 100;

  // one request as seen on the input channel
  typedef struct {
    func_t                 func;
    logic [SET_W-1:0]      wset;
    logic [ROW_W-1:0]      row;
    logic [ROW_W-1:0]      tap;
    logic signed [WGT_W-1:0] weight;
    pix_row_t              pix;
    logic                  last;
  } pixel_req_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    func = 1'b0;
  logic [SET_W-1:0]        set_index = '0;
  logic [ROW_W-1:0]        row_index = '0;
  logic [ROW_W-1:0]        tap_index = '0;
  logic signed [WGT_W-1:0] weight_value = '0;
  logic [PIX_W-1:0]        pix_a = '0;
  logic [PIX_W-1:0]        pix_b = '0;
  logic [PIX_W-1:0]        pix_c = '0;
  logic [PIX_W-1:0]        pix_d = '0;
  logic [PIX_W-1:0]        pix_e = '0;
  logic [PIX_W-1:0]        pix_f = '0;
  logic                    last_row = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [OUT_W-1:0]        pixel_out;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;

  // predictor state: weight store, write tracking, running sum, register shadow
  logic signed [WGT_W-1:0] weights [NUM_SETS][LUMA_TAPS][LUMA_TAPS];
  bit                      loaded [NUM_SETS][LUMA_TAPS][LUMA_TAPS];
  logic [ACC_W-1:0]        window_sum = '0;
  logic                    cfg_chroma = 1'b0;
  logic                    cfg_hbd = 1'b0;
  logic [SHIFT_W-1:0]      cfg_shift = DESCALE_RESET;

  logic [OUT_W-1:0]        expected_pixels [$];
  logic [OUT_W-1:0]        want_pix;
  int                      preloaded_sets [4] = '{0, 21, 42, 63};
  int                      requests_sent = 0;
  int                      error_count = 0;
  int                      cycle_count = 0;
  int                      stall_left = 0;
  bit                      quiet_mode = 1'b0;

  table_weighted_2d_upsample_filter #(
    .NUM_WEIGHT_SETS(NUM_SETS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .set_index    (set_index),
    .row_index    (row_index),
    .tap_index    (tap_index),
    .weight_value (weight_value),
    .pix_a        (pix_a),
    .pix_b        (pix_b),
    .pix_c        (pix_c),
    .pix_d        (pix_d),
    .pix_e        (pix_e),
    .pix_f        (pix_f),
    .last_row     (last_row),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_out    (pixel_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // random back-pressure on the result side, drawn per accepted pixel
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      stall_left = quiet_mode ? 0 : $urandom_range(0, MAX_IDLE);
    else if (stall_left > 0)
      stall_left--;
    out_stall <= (stall_left > 0);
  end

  // compare each accepted pixel with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: pixel_out actual %0d", pixel_out);
        error_count++;
      end else begin
        want_pix = expected_pixels.pop_front();
        if (pixel_out !== want_pix) begin
          $error("pixel_out mismatch: expected %0d, actual %0d", want_pix, pixel_out);
          error_count++;
        end
      end
    end
  end

  // update the predictor with one accepted request
  task automatic predict_request(input pixel_req_t r);
    int ntaps;
    int c;
    int prod;
    int sh;
    int s;
    int v;
    int lim;
    logic [ACC_W-1:0] rnd;
    if (r.func == FUNC_LOAD) begin
      // writes outside the 6x6 set are dropped
      if (r.row < LUMA_TAPS && r.tap < LUMA_TAPS) begin
        weights[r.wset][r.row][r.tap] = r.weight;
        loaded[r.wset][r.row][r.tap] = 1'b1;
      end
    end else begin
      ntaps = cfg_chroma ? CHROMA_TAPS : LUMA_TAPS;
      // rows beyond the window add nothing
      if (r.row < ntaps)
        for (c = 0; c < ntaps; c++) begin
          prod = int'(r.pix[c]) * int'(weights[r.wset][r.row][c]);
          window_sum = window_sum + ACC_W'(prod);
        end
      if (r.last) begin
        sh = cfg_shift;
        rnd = (sh != 0) ? (32'd1 << (sh - 1)) : 32'd0;
        s = int'(window_sum + rnd);
        v = s >>> sh;
        lim = cfg_hbd ? int'(CLIP_MAX_16) : int'(CLIP_MAX_8);
        if (v < 0)
          v = 0;
        else if (v > lim)
          v = lim;
        expected_pixels.push_back(OUT_W'(v));
        window_sum = '0;
      end
    end
  endtask

  // drive one request after a random gap and wait for it to be taken
  task automatic send_request(input pixel_req_t r);
    int gap;
    gap = quiet_mode ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= r.func;
    set_index    <= r.wset;
    row_index    <= r.row;
    tap_index    <= r.tap;
    weight_value <= r.weight;
    pix_a        <= r.pix[0];
    pix_b        <= r.pix[1];
    pix_c        <= r.pix[2];
    pix_d        <= r.pix[3];
    pix_e        <= r.pix[4];
    pix_f        <= r.pix[5];
    last_row     <= r.last;
    do @(posedge clk); while (in_stall);
    predict_request(r);
    requests_sent++;
  endtask

  // let every pending pixel arrive, then allow the pipeline to settle
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write; valid is left high for a following write
  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CHROMA_MODE:    cfg_chroma = value[0];
      REG_HIGH_BIT_DEPTH: cfg_hbd = value[0];
      REG_DESCALE:        cfg_shift = value[SHIFT_W-1:0];
      default: ;
    endcase
  endtask

  // full register update, only called with the block idle
  task automatic set_config(input bit chroma, input bit hbd, input int shift);
    write_register(REG_CHROMA_MODE, CFG_DATA_W'(chroma));
    write_register(REG_HIGH_BIT_DEPTH, CFG_DATA_W'(hbd));
    write_register(REG_DESCALE, CFG_DATA_W'(shift));
    cfg_valid <= 1'b0;
  endtask

  function automatic pixel_req_t make_load(input int wset, input int row, input int tap,
                                           input int weight);
    pixel_req_t r;
    r.func   = FUNC_LOAD;
    r.wset   = SET_W'(wset);
    r.row    = ROW_W'(row);
    r.tap    = ROW_W'(tap);
    r.weight = WGT_W'(weight);
    r.pix    = rand_pixels();
    r.last   = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic pixel_req_t make_filter(input int wset, input int row,
                                             input pix_row_t pix, input bit last);
    pixel_req_t r;
    r.func   = FUNC_FILTER;
    r.wset   = SET_W'(wset);
    r.row    = ROW_W'(row);
    r.tap    = ROW_W'($urandom);
    r.weight = WGT_W'($urandom);
    r.pix    = pix;
    r.last   = last;
    return r;
  endfunction

  // random row with a fair share of black and full-scale pixels
  function automatic pix_row_t rand_pixels();
    pix_row_t p;
    int c;
    for (c = 0; c < LUMA_TAPS; c++)
      case ($urandom_range(0, 7))
        0:       p[c] = '0;
        1:       p[c] = '1;
        default: p[c] = PIX_W'($urandom);
      endcase
    return p;
  endfunction

  // a set whose rows lo..hi are written for the current tap count
  function automatic int ready_set(input int lo, input int hi, input int ntaps);
    int s;
    int r;
    int c;
    s = $urandom_range(0, NUM_SETS - 1);
    for (r = lo; r <= hi; r++)
      for (c = 0; c < ntaps; c++)
        if (!loaded[s][r][c])
          return preloaded_sets[$urandom_range(0, 3)];
    return s;
  endfunction

  // fill four sets: all max positive, all max negative, two random
  task automatic test_preload_weights();
    int i;
    int r;
    int c;
    int w;
    for (i = 0; i < 4; i++)
      for (r = 0; r < LUMA_TAPS; r++)
        for (c = 0; c < LUMA_TAPS; c++) begin
          case (preloaded_sets[i])
            0:       w = 32767;
            63:      w = -32768;
            default: w = $urandom;
          endcase
          send_request(make_load(preloaded_sets[i], r, c, w));
        end
  endtask

  // loads outside the set must not disturb stored weights
  task automatic test_load_bounds();
    send_request(make_load(0, 6, 0, $urandom));
    send_request(make_load(0, 0, 6, $urandom));
    send_request(make_load(0, 7, 7, $urandom));
    send_request(make_filter(0, 0, {LUMA_TAPS{PIX_W'(1)}}, 1'b1));
  endtask

  // rows past the window add nothing but last still emits
  task automatic test_row_bounds();
    send_request(make_filter(21, 6, rand_pixels(), 1'b0));
    send_request(make_filter(21, 7, rand_pixels(), 1'b1));
  endtask

  // overflow to the 8-bit ceiling, negative to zero, zero input
  task automatic test_clip_limits();
    send_request(make_filter(0, 5, '1, 1'b1));
    send_request(make_filter(63, 2, '1, 1'b1));
    send_request(make_filter(42, 3, '0, 1'b1));
  endtask

  // eleven max-negative rows push the sum past -2^31 so it wraps
  task automatic test_sum_wrap();
    int i;
    for (i = 0; i < 11; i++)
      send_request(make_filter(63, 0, '1, i == 10));
  endtask

  // 4x4 window with the two unused columns 4 and 5 at full scale, then a stray row
  task automatic test_chroma_window();
    pix_row_t p;
    int r;
    drain_pipeline();
    set_config(1'b1, 1'b0, DESCALE_RESET);
    for (r = 0; r < CHROMA_TAPS; r++) begin
      p = rand_pixels();
      p[4] = '1;
      p[5] = '1;
      send_request(make_filter(21, r, p, r == CHROMA_TAPS - 1));
    end
    send_request(make_filter(21, 4, rand_pixels(), 1'b1));
  endtask

  // no shift, the widest shift and the narrowest one at high bit depth
  task automatic test_shift_extremes();
    drain_pipeline();
    set_config(1'b0, 1'b1, 0);
    send_request(make_filter(0, 0, {LUMA_TAPS{PIX_W'(1)}}, 1'b1));
    drain_pipeline();
    set_config(1'b0, 1'b1, 31);
    send_request(make_filter(42, 1, rand_pixels(), 1'b1));
    drain_pipeline();
    set_config(1'b1, 1'b1, 1);
    send_request(make_filter(42, 2, rand_pixels(), 1'b1));
  endtask

  // random phases: mostly whole windows, plus loads, cut windows and stray rows
  task automatic test_random_traffic();
    int target;
    int phase_end;
    int ntaps;
    int kind;
    int s;
    int r;
    int t;
    int cut;
    int shift;
    target = requests_sent + RANDOM_ITEMS;
    while (requests_sent < target) begin
      drain_pipeline();
      case ($urandom_range(0, 5))
        0:       shift = 0;
        1:       shift = 31;
        2:       shift = 1;
        3:       shift = 20;
        default: shift = $urandom_range(8, 20);
      endcase
      set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), shift);
      quiet_mode = ($urandom_range(0, 3) == 0);
      ntaps = cfg_chroma ? CHROMA_TAPS : LUMA_TAPS;
      phase_end = requests_sent + PHASE_ITEMS;
      while (requests_sent < phase_end) begin
        kind = $urandom_range(0, 19);
        if (kind < 14) begin
          // window, now and then ended early
          cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ntaps - 1) : ntaps - 1;
          s = ready_set(0, ntaps - 1, ntaps);
          for (r = 0; r <= cut; r++)
            send_request(make_filter(s, r, rand_pixels(), r == cut));
        end else if (kind < 17) begin
          // weight update, some outside the set
          s = $urandom_range(0, 1) ? preloaded_sets[$urandom_range(0, 3)]
                                   : $urandom_range(0, NUM_SETS - 1);
          r = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
          t = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
          send_request(make_load(s, r, t, $urandom));
        end else begin
          // stray row with random last
          r = $urandom_range(0, 7);
          s = (r < ntaps) ? ready_set(r, r, ntaps) : $urandom_range(0, NUM_SETS - 1);
          send_request(make_filter(s, r, rand_pixels(), 1'($urandom_range(0, 1))));
        end
      end
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_preload_weights();
    test_load_bounds();
    test_row_bounds();
    test_clip_limits();
    test_sum_wrap();
    test_chroma_window();
    test_shift_extremes();
    test_random_traffic();
    drain_pipeline();
    if (expected_pixels.size() != 0) begin
      $error("%0d predicted pixels never arrived", expected_pixels.size());
      error_count++;
    end
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
